// File: hdl/rpte_pkg.sv
// ----------------------------------------------------------------------------
// rpte_pkg
// Shared types, constants and sequencer microprograms for the radar
// polar-to-ego transform.
// ----------------------------------------------------------------------------
package rpte_pkg;

   localparam int ID_WIDTH_DEF  = 32;
   localparam int FRAC_BITS_DEF = 8;

   localparam int ANG_W    = 16;
   localparam int OFF_W    = 17;
   localparam int CSR_W    = 17;
   localparam int CSR_IDX_W = 3;
   localparam int OBJ_ID_W = 32;
   localparam int STAMP_W  = 64;
   localparam int POS_W    = 18;
   localparam int VEL_W    = 16;
   localparam int Q_W      = 18;   // Q16 trig and matrix values
   localparam int A_W      = 36;   // multiplier operand A
   localparam int PROD_W   = A_W + Q_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int CORDIC_N = 16;
   localparam int CRD_W    = 33;
   localparam int STEP_W   = 5;

   localparam logic signed [CRD_W-1:0] CORDIC_X0 = 33'sd652032874;
   localparam logic signed [Q_W-1:0]   Q16_ONE   = 18'sd65536;

   localparam logic [31:0] ATAN_TAB [CORDIC_N] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_YAW   = 3'd0,
      CSR_PITCH = 3'd1,
      CSR_ROLL  = 3'd2,
      CSR_OFFX  = 3'd3,
      CSR_OFFY  = 3'd4,
      CSR_OFFZ  = 3'd5
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ANG_START, ST_ANG_WAIT, ST_MAC, ST_DRAIN0, ST_DRAIN1, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      A_C0, A_S0, A_C1, A_S1, A_C2, A_S2, A_CYSP, A_SYSP,
      A_RANGE, A_T, A_RR, A_COEF, A_OFF
   } asel_type;

   typedef enum logic [3:0] {
      B_C0, B_S0, B_C1, B_S1, B_C2, B_S2, B_ONE, B_XS, B_YS, B_ZS
   } bsel_type;

   typedef enum logic [3:0] {
      D_NONE, D_CYSP, D_SYSP, D_COEF, D_T, D_XS, D_YS, D_ZS, D_POS, D_VELX, D_VELY
   } dest_type;

   typedef struct packed {
      logic     en;
      logic     clr;
      logic     sub;
      logic     rnd;
      dest_type dest;
      logic [3:0] didx;
   } mac_ctrl_type;

   typedef struct packed {
      asel_type     asel;
      logic [3:0]   aidx;
      bsel_type     bsel;
      mac_ctrl_type ctrl;
   } op_type;

   localparam logic [STEP_W-1:0] BUILD_LAST = 5'd14;
   localparam logic [STEP_W-1:0] ITEM_LAST  = 5'd17;

   function automatic op_type mk_op(input asel_type asel, input logic [3:0] aidx,
                                    input bsel_type bsel, input logic clr,
                                    input logic sub, input logic rnd,
                                    input dest_type dest, input logic [3:0] didx);
      op_type o;
      o.asel      = asel;
      o.aidx      = aidx;
      o.bsel      = bsel;
      o.ctrl.en   = 1'b1;
      o.ctrl.clr  = clr;
      o.ctrl.sub  = sub;
      o.ctrl.rnd  = rnd;
      o.ctrl.dest = dest;
      o.ctrl.didx = didx;
      return o;
   endfunction

   // Slots: 0 yaw, 1 pitch, 2 roll.
   function automatic op_type build_op(input logic [STEP_W-1:0] step);
      op_type o;
      case (step)
         5'd0:  o = mk_op(A_C0,   4'd0, B_S1, 1'b1, 1'b0, 1'b1, D_CYSP, 4'd0);
         5'd1:  o = mk_op(A_S0,   4'd0, B_S1, 1'b1, 1'b0, 1'b1, D_SYSP, 4'd0);
         5'd2:  o = mk_op(A_C0,   4'd0, B_C1, 1'b1, 1'b0, 1'b1, D_COEF, 4'd0);
         5'd3:  o = mk_op(A_S0,   4'd0, B_C1, 1'b1, 1'b0, 1'b1, D_COEF, 4'd3);
         5'd4:  o = mk_op(A_S1,   4'd0, B_ONE, 1'b1, 1'b1, 1'b1, D_COEF, 4'd6);
         5'd5:  o = mk_op(A_C1,   4'd0, B_S2, 1'b1, 1'b0, 1'b1, D_COEF, 4'd7);
         5'd6:  o = mk_op(A_C1,   4'd0, B_C2, 1'b1, 1'b0, 1'b1, D_COEF, 4'd8);
         5'd7:  o = mk_op(A_CYSP, 4'd0, B_S2, 1'b1, 1'b0, 1'b1, D_NONE, 4'd0);
         5'd8:  o = mk_op(A_S0,   4'd0, B_C2, 1'b0, 1'b1, 1'b1, D_COEF, 4'd1);
         5'd9:  o = mk_op(A_CYSP, 4'd0, B_C2, 1'b1, 1'b0, 1'b1, D_NONE, 4'd0);
         5'd10: o = mk_op(A_S0,   4'd0, B_S2, 1'b0, 1'b0, 1'b1, D_COEF, 4'd2);
         5'd11: o = mk_op(A_SYSP, 4'd0, B_S2, 1'b1, 1'b0, 1'b1, D_NONE, 4'd0);
         5'd12: o = mk_op(A_C0,   4'd0, B_C2, 1'b0, 1'b0, 1'b1, D_COEF, 4'd4);
         5'd13: o = mk_op(A_SYSP, 4'd0, B_C2, 1'b1, 1'b0, 1'b1, D_NONE, 4'd0);
         5'd14: o = mk_op(A_C0,   4'd0, B_S2, 1'b0, 1'b1, 1'b1, D_COEF, 4'd5);
         default: begin
            o         = '0;
            o.ctrl.en = 1'b0;
         end
      endcase
      return o;
   endfunction

   // Slots: 0 azimuth, 1 elevation.
   function automatic op_type item_op(input logic [STEP_W-1:0] step);
      op_type o;
      case (step)
         5'd0:  o = mk_op(A_RANGE, 4'd0, B_C1,  1'b1, 1'b0, 1'b0, D_T,    4'd0);
         5'd1:  o = mk_op(A_RANGE, 4'd0, B_S1,  1'b1, 1'b0, 1'b1, D_ZS,   4'd0);
         5'd2:  o = mk_op(A_RR,    4'd0, B_C0,  1'b1, 1'b1, 1'b1, D_VELX, 4'd0);
         5'd3:  o = mk_op(A_T,     4'd0, B_C0,  1'b1, 1'b0, 1'b0, D_XS,   4'd0);
         5'd4:  o = mk_op(A_T,     4'd0, B_S0,  1'b1, 1'b0, 1'b0, D_YS,   4'd0);
         5'd5:  o = mk_op(A_RR,    4'd0, B_S0,  1'b1, 1'b1, 1'b1, D_VELY, 4'd0);
         5'd6:  o = mk_op(A_OFF,   4'd0, B_ONE, 1'b1, 1'b0, 1'b0, D_NONE, 4'd0);
         5'd7:  o = mk_op(A_COEF,  4'd0, B_XS,  1'b0, 1'b0, 1'b0, D_NONE, 4'd0);
         5'd8:  o = mk_op(A_COEF,  4'd1, B_YS,  1'b0, 1'b0, 1'b0, D_NONE, 4'd0);
         5'd9:  o = mk_op(A_COEF,  4'd2, B_ZS,  1'b0, 1'b0, 1'b0, D_POS,  4'd0);
         5'd10: o = mk_op(A_OFF,   4'd1, B_ONE, 1'b1, 1'b0, 1'b0, D_NONE, 4'd0);
         5'd11: o = mk_op(A_COEF,  4'd3, B_XS,  1'b0, 1'b0, 1'b0, D_NONE, 4'd0);
         5'd12: o = mk_op(A_COEF,  4'd4, B_YS,  1'b0, 1'b0, 1'b0, D_NONE, 4'd0);
         5'd13: o = mk_op(A_COEF,  4'd5, B_ZS,  1'b0, 1'b0, 1'b0, D_POS,  4'd1);
         5'd14: o = mk_op(A_OFF,   4'd2, B_ONE, 1'b1, 1'b0, 1'b0, D_NONE, 4'd0);
         5'd15: o = mk_op(A_COEF,  4'd6, B_XS,  1'b0, 1'b0, 1'b0, D_NONE, 4'd0);
         5'd16: o = mk_op(A_COEF,  4'd7, B_YS,  1'b0, 1'b0, 1'b0, D_NONE, 4'd0);
         5'd17: o = mk_op(A_COEF,  4'd8, B_ZS,  1'b0, 1'b0, 1'b0, D_POS,  4'd2);
         default: begin
            o         = '0;
            o.ctrl.en = 1'b0;
         end
      endcase
      return o;
   endfunction

   function automatic logic signed [POS_W-1:0] sat18(input logic signed [ACC_W-1:0] v);
      if (v > 56'sd131071) return 18'sd131071;
      if (v < -56'sd131072) return -18'sd131072;
      return v[POS_W-1:0];
   endfunction

   function automatic logic signed [VEL_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
      if (v > 56'sd32767) return 16'sd32767;
      if (v < -56'sd32768) return -16'sd32768;
      return v[VEL_W-1:0];
   endfunction

endpackage

// File: hdl/radar_polar_to_ego_transform.sv
// ----------------------------------------------------------------------------
// radar_polar_to_ego_transform
// Converts radar detections from polar sensor form to the ego frame.
// ----------------------------------------------------------------------------
// Usage
//   req_* carries one detection per item (valid/ready). Detections whose range
//   lies outside 0.5 m .. 200 m are taken and dropped without a result or id.
//   rsp_* carries one result item per kept detection (valid/ready).
//   csr_* writes mounting angles and offsets; the user must write them only
//   while the block is idle, which the block itself does not enforce. An
//   angle write rebuilds the rotation matrix with req_ready low throughout.
//   One shared CORDIC (16 rotations, one per cycle) and one shared 36x18
//   multiply-accumulate under a microcoded sequencer do all the work. An
//   item takes two sine/cosine runs, 18 multiply steps, the drain states
//   ST_DRAIN0 and ST_DRAIN1 and the output state ST_OUT. One item is in
//   work at a time. A finished result sits in the output register; the
//   next item is taken while it waits, and a stalled receiver only holds the
//   sequencer once a second result is ready.
//   Reset clears the id counter, zeroes the control state, angles and offsets
//   and loads the identity matrix; the block is ready on the next cycle.
// ----------------------------------------------------------------------------
module radar_polar_to_ego_transform #(
   parameter int ID_WIDTH  = rpte_pkg::ID_WIDTH_DEF,
   parameter int FRAC_BITS = rpte_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [15:0]                           req_range,
   input  logic signed [rpte_pkg::ANG_W-1:0]     req_azimuth,
   input  logic signed [rpte_pkg::ANG_W-1:0]     req_elevation,
   input  logic signed [15:0]                    req_range_rate,
   input  logic [rpte_pkg::STAMP_W-1:0]          req_timestamp,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rpte_pkg::OBJ_ID_W-1:0]         rsp_object_id,
   output logic signed [rpte_pkg::POS_W-1:0]     rsp_pos_x,
   output logic signed [rpte_pkg::POS_W-1:0]     rsp_pos_y,
   output logic signed [rpte_pkg::POS_W-1:0]     rsp_pos_z,
   output logic signed [rpte_pkg::VEL_W-1:0]     rsp_vel_x,
   output logic signed [rpte_pkg::VEL_W-1:0]     rsp_vel_y,
   output logic [rpte_pkg::STAMP_W-1:0]          rsp_stamp_out,
   input  logic                                  csr_wr_en,
   input  logic [rpte_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rpte_pkg::CSR_W-1:0]            csr_wdata
);
   import rpte_pkg::*;

   localparam int unsigned RANGE_MIN = 1 << (FRAC_BITS - 1);
   localparam int unsigned RANGE_MAX = 200 << FRAC_BITS;

   // configuration
   logic [ANG_W-1:0] ang_reg_ff [3];
   logic signed [OFF_W-1:0] off_ff [3];

   // control
   state_type state_ff, state_in;
   logic item_mode_ff, item_mode_in;
   logic pend_ff, pend_in;
   logic [1:0] ang_idx_ff, ang_idx_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [ID_WIDTH-1:0] id_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, in_range, angle_write, cordic_start, load_rsp, build_go;
   logic [31:0] range_ext;

   // item capture
   logic [15:0] range_ff;
   logic signed [ANG_W-1:0] az_ff, el_ff;
   logic signed [15:0] rr_ff;
   logic [STAMP_W-1:0] stamp_ff;

   // datapath values
   logic signed [Q_W-1:0] cos_ff [3], sin_ff [3];
   logic signed [Q_W-1:0] cysp_ff, sysp_ff, xs_ff, ys_ff, zs_ff;
   logic signed [Q_W-1:0] coef_ff [9];
   logic signed [A_W-1:0] t_ff;
   logic signed [POS_W-1:0] pos_ff [3];
   logic signed [VEL_W-1:0] velx_ff, vely_ff;

   // output register
   logic [OBJ_ID_W-1:0] o_id_ff;
   logic signed [POS_W-1:0] o_px_ff, o_py_ff, o_pz_ff;
   logic signed [VEL_W-1:0] o_vx_ff, o_vy_ff;
   logic [STAMP_W-1:0] o_stamp_ff;

   // shared units
   logic [ANG_W-1:0] cordic_angle;
   logic cordic_done;
   logic signed [Q_W-1:0] cordic_cos, cordic_sin;
   op_type op;
   mac_ctrl_type mac_ctrl;
   logic signed [A_W-1:0] op_a;
   logic signed [Q_W-1:0] op_b;
   logic res_valid;
   dest_type res_dest;
   logic [3:0] res_didx;
   logic signed [ACC_W-1:0] res_value;

   rpte_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (cordic_angle),
      .done  (cordic_done),
      .cos_q (cordic_cos),
      .sin_q (cordic_sin)
   );

   rpte_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .op_a      (op_a),
      .op_b      (op_b),
      .res_valid (res_valid),
      .res_dest  (res_dest),
      .res_didx  (res_didx),
      .res_value (res_value)
   );

   assign angle_write = csr_wr_en &&
      (csr_index == CSR_YAW || csr_index == CSR_PITCH || csr_index == CSR_ROLL);
   assign req_ready = (state_ff == ST_IDLE) && !pend_ff && !angle_write;
   assign accept    = req_valid && req_ready;
   assign range_ext = 32'(req_range);
   assign in_range  = (range_ext >= 32'(RANGE_MIN)) && (range_ext <= 32'(RANGE_MAX));

   always_comb begin
      if (item_mode_ff) begin
         cordic_angle = (ang_idx_ff == 2'd0) ? az_ff : el_ff;
      end else begin
         case (ang_idx_ff)
            2'd0:    cordic_angle = ang_reg_ff[0];
            2'd1:    cordic_angle = ang_reg_ff[1];
            default: cordic_angle = ang_reg_ff[2];
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      item_mode_in = item_mode_ff;
      ang_idx_in   = ang_idx_ff;
      step_in      = step_ff;
      cordic_start = 1'b0;
      load_rsp     = 1'b0;
      build_go     = 1'b0;
      op           = item_mode_ff ? item_op(step_ff) : build_op(step_ff);
      mac_ctrl     = op.ctrl;
      mac_ctrl.en  = op.ctrl.en && (state_ff == ST_MAC);
      case (state_ff)
         ST_IDLE: begin
            ang_idx_in = '0;
            step_in    = '0;
            if (accept) begin
               if (in_range) begin
                  item_mode_in = 1'b1;
                  state_in     = ST_ANG_START;
               end
            end else if (pend_ff) begin
               build_go     = 1'b1;
               item_mode_in = 1'b0;
               state_in     = ST_ANG_START;
            end
         end
         ST_ANG_START: begin
            cordic_start = 1'b1;
            state_in     = ST_ANG_WAIT;
         end
         ST_ANG_WAIT: begin
            if (cordic_done) begin
               if ((item_mode_ff && ang_idx_ff == 2'd1) ||
                   (!item_mode_ff && ang_idx_ff == 2'd2)) begin
                  state_in = ST_MAC;
               end else begin
                  ang_idx_in = ang_idx_ff + 2'd1;
                  state_in   = ST_ANG_START;
               end
            end
         end
         ST_MAC: begin
            step_in = step_ff + 5'd1;
            if (step_ff == (item_mode_ff ? ITEM_LAST : BUILD_LAST)) begin
               state_in = ST_DRAIN0;
            end
         end
         ST_DRAIN0: state_in = ST_DRAIN1;
         ST_DRAIN1: state_in = item_mode_ff ? ST_OUT : ST_IDLE;
         ST_OUT: begin
            // hold until the output register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      pend_in      = (pend_ff && !build_go) || angle_write;
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   // operand select
   always_comb begin
      case (op.asel)
         A_C0:    op_a = A_W'(cos_ff[0]);
         A_S0:    op_a = A_W'(sin_ff[0]);
         A_C1:    op_a = A_W'(cos_ff[1]);
         A_S1:    op_a = A_W'(sin_ff[1]);
         A_C2:    op_a = A_W'(cos_ff[2]);
         A_S2:    op_a = A_W'(sin_ff[2]);
         A_CYSP:  op_a = A_W'(cysp_ff);
         A_SYSP:  op_a = A_W'(sysp_ff);
         A_RANGE: op_a = A_W'($signed({1'b0, range_ff}));
         A_T:     op_a = t_ff;
         A_RR:    op_a = A_W'(rr_ff);
         A_COEF:  op_a = A_W'(coef_ff[op.aidx]);
         A_OFF:   op_a = A_W'(off_ff[op.aidx[1:0]]);
         default: op_a = '0;
      endcase
      case (op.bsel)
         B_C0:    op_b = cos_ff[0];
         B_S0:    op_b = sin_ff[0];
         B_C1:    op_b = cos_ff[1];
         B_S1:    op_b = sin_ff[1];
         B_C2:    op_b = cos_ff[2];
         B_S2:    op_b = sin_ff[2];
         B_ONE:   op_b = Q16_ONE;
         B_XS:    op_b = xs_ff;
         B_YS:    op_b = ys_ff;
         B_ZS:    op_b = zs_ff;
         default: op_b = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         item_mode_ff <= 1'b0;
         pend_ff      <= 1'b0;
         ang_idx_ff   <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         id_ff        <= '0;
         for (int i = 0; i < 3; i++) begin
            ang_reg_ff[i] <= '0;
            off_ff[i]     <= '0;
         end
      end else begin
         state_ff     <= state_in;
         item_mode_ff <= item_mode_in;
         pend_ff      <= pend_in;
         ang_idx_ff   <= ang_idx_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_rsp) begin
            id_ff <= id_ff + ID_WIDTH'(1);
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_YAW:   ang_reg_ff[0] <= csr_wdata[ANG_W-1:0];
               CSR_PITCH: ang_reg_ff[1] <= csr_wdata[ANG_W-1:0];
               CSR_ROLL:  ang_reg_ff[2] <= csr_wdata[ANG_W-1:0];
               CSR_OFFX:  off_ff[0]     <= csr_wdata;
               CSR_OFFY:  off_ff[1]     <= csr_wdata;
               CSR_OFFZ:  off_ff[2]     <= csr_wdata;
               default:   ;
            endcase
         end
      end
   end

   // rotation matrix, identity after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            coef_ff[i] <= (i % 4 == 0) ? Q16_ONE : '0;
         end
      end else if (res_valid && res_dest == D_COEF) begin
         coef_ff[res_didx] <= sat18(res_value);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         range_ff <= req_range;
         az_ff    <= req_azimuth;
         el_ff    <= req_elevation;
         rr_ff    <= req_range_rate;
         stamp_ff <= req_timestamp;
      end
      if (cordic_done) begin
         cos_ff[ang_idx_ff] <= cordic_cos;
         sin_ff[ang_idx_ff] <= cordic_sin;
      end
      if (res_valid) begin
         case (res_dest)
            D_CYSP: cysp_ff <= sat18(res_value);
            D_SYSP: sysp_ff <= sat18(res_value);
            D_T:    t_ff    <= res_value[A_W-1:0];
            D_XS:   xs_ff   <= Q_W'((res_value + (56'sd1 <<< 31)) >>> 32);
            D_YS:   ys_ff   <= Q_W'((res_value + (56'sd1 <<< 31)) >>> 32);
            D_ZS:   zs_ff   <= res_value[Q_W-1:0];
            D_POS:  pos_ff[res_didx[1:0]] <= sat18((res_value + 56'sd32768) >>> 16);
            D_VELX: velx_ff <= sat16(res_value);
            D_VELY: vely_ff <= sat16(res_value);
            default: ;
         endcase
      end
      if (load_rsp) begin
         o_id_ff    <= OBJ_ID_W'(id_ff);
         o_px_ff    <= pos_ff[0];
         o_py_ff    <= pos_ff[1];
         o_pz_ff    <= pos_ff[2];
         o_vx_ff    <= velx_ff;
         o_vy_ff    <= vely_ff;
         o_stamp_ff <= stamp_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_object_id = o_id_ff;
   assign rsp_pos_x     = o_px_ff;
   assign rsp_pos_y     = o_py_ff;
   assign rsp_pos_z     = o_pz_ff;
   assign rsp_vel_x     = o_vx_ff;
   assign rsp_vel_y     = o_vy_ff;
   assign rsp_stamp_out = o_stamp_ff;

endmodule

// File: hdl/rpte_cordic.sv
// ----------------------------------------------------------------------------
// rpte_cordic
// Iterative sine/cosine unit: one CORDIC rotation per cycle, Q16 results.
// ----------------------------------------------------------------------------
module rpte_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [rpte_pkg::ANG_W-1:0]          angle,
   output logic                                done,
   output logic signed [rpte_pkg::Q_W-1:0]     cos_q,
   output logic signed [rpte_pkg::Q_W-1:0]     sin_q
);
   import rpte_pkg::*;

   logic busy_ff, busy_in, fin_ff, fin_in, done_ff, done_in;
   logic [3:0] iter_ff, iter_in;
   logic flip_ff, flip_in;
   logic signed [CRD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [Q_W-1:0] cos_ff, cos_in, sin_ff, sin_in;

   logic [31:0] a32, a_adj;
   logic start_flip;
   logic signed [CRD_W-1:0] dx, dy, atan_v, xr, yr;

   always_comb begin
      a32        = {angle, 16'b0};
      start_flip = a32[31] ^ a32[30];
      a_adj      = start_flip ? (a32 ^ 32'h8000_0000) : a32;
      dx         = y_ff >>> iter_ff;
      dy         = x_ff >>> iter_ff;
      atan_v     = $signed({1'b0, ATAN_TAB[iter_ff]});
      xr         = (x_ff + 33'sd8192) >>> 14;
      yr         = (y_ff + 33'sd8192) >>> 14;
      if (flip_ff) begin
         xr = -xr;
         yr = -yr;
      end
      if (xr > 33'sd65536)  xr = 33'sd65536;
      if (xr < -33'sd65536) xr = -33'sd65536;
      if (yr > 33'sd65536)  yr = 33'sd65536;
      if (yr < -33'sd65536) yr = -33'sd65536;

      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      iter_in = iter_ff;
      flip_in = flip_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         flip_in = start_flip;
         x_in    = CORDIC_X0;
         y_in    = '0;
         z_in    = $signed({a_adj[31], a_adj});
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_v;
         end
         iter_in = iter_ff + 4'd1;
         if (iter_ff == 4'(CORDIC_N - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         cos_in  = xr[Q_W-1:0];
         sin_in  = yr[Q_W-1:0];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign done  = done_ff;
   assign cos_q = cos_ff;
   assign sin_q = sin_ff;

endmodule

// File: hdl/rpte_mac.sv
// ----------------------------------------------------------------------------
// rpte_mac
// Shared multiply-accumulate: registered product, then optional Q16 rounding
// and add or subtract into the accumulator. Tags the result with its target.
// ----------------------------------------------------------------------------
module rpte_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  rpte_pkg::mac_ctrl_type              ctrl,
   input  logic signed [rpte_pkg::A_W-1:0]     op_a,
   input  logic signed [rpte_pkg::Q_W-1:0]     op_b,
   output logic                                res_valid,
   output rpte_pkg::dest_type                  res_dest,
   output logic [3:0]                          res_didx,
   output logic signed [rpte_pkg::ACC_W-1:0]   res_value
);
   import rpte_pkg::*;

   mac_ctrl_type ctrl_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in, term, base;

   always_comb begin
      term = ACC_W'(prod_ff);
      if (ctrl_ff.rnd) begin
         term = (term + 56'sd32768) >>> 16;
      end
      base   = ctrl_ff.clr ? '0 : acc_ff;
      acc_in = ctrl_ff.sub ? (base - term) : (base + term);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
      if (ctrl_ff.en) begin
         acc_ff <= acc_in;
      end
   end

   assign res_valid = ctrl_ff.en && (ctrl_ff.dest != D_NONE);
   assign res_dest  = ctrl_ff.dest;
   assign res_didx  = ctrl_ff.didx;
   assign res_value = acc_in;

endmodule

// File: verif/radar_polar_to_ego_transform_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_polar_to_ego_transform_tb
// Self-checking bench for the radar polar-to-ego transform. Drives detections
// through the request channel under several mounting settings, predicts each
// kept detection's ego position, velocity, id and stamp, and compares them
// with the result channel in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module radar_polar_to_ego_transform_tb;
   import rpte_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam longint RANGE_MIN = 128;     // 0.5 m
   localparam longint RANGE_MAX = 51200;   // 200 m

   typedef struct {
      logic [15:0] range;
      logic [15:0] az;
      logic [15:0] el;
      logic [15:0] rr;
      logic [63:0] stamp;
   } det_type;

   typedef struct {
      logic [31:0]      id;
      logic [2:0][17:0] pos;
      logic [15:0]      vx;
      logic [15:0]      vy;
      logic [63:0]      stamp;
   } track_type;

   class ego_scoreboard;
      track_type   expected_q[$];
      logic [31:0] id_cnt;
      logic [15:0] angle[3];
      longint      offset[3];
      longint      rot[9];

      function new();
         id_cnt = '0;
         for (int i = 0; i < 3; i++) begin
            angle[i] = '0;
            offset[i] = 0;
         end
         for (int i = 0; i < 9; i++) rot[i] = (i % 4 == 0) ? 65536 : 0;
      endfunction

      static function longint rnd(longint v, int s);
         return (v + (longint'(1) << (s - 1))) >>> s;
      endfunction

      static function longint sat(longint v, int w);
         longint hi;
         hi = (longint'(1) << (w - 1)) - 1;
         if (v > hi) return hi;
         if (v < -hi - 1) return -hi - 1;
         return v;
      endfunction

      static function void sincos(input logic [15:0] ang, output longint c,
                                  output longint s);
         logic [31:0] a;
         bit          flip;
         longint      x, y, z, dx, dy;
         a = {ang, 16'h0000};
         flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
         if (flip) a = a + 32'h8000_0000;
         z = longint'($signed(a));
         x = 652032874;
         y = 0;
         for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end else begin
               x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
         end
         x = rnd(x, 14);
         y = rnd(y, 14);
         if (flip) begin
            x = -x; y = -y;
         end
         c = (x > 65536) ? 65536 : ((x < -65536) ? -65536 : x);
         s = (y > 65536) ? 65536 : ((y < -65536) ? -65536 : y);
      endfunction

      function void rebuild_rotation();
         longint cy, sy, cp, sp, cr, sr, cysp, sysp;
         sincos(angle[0], cy, sy);
         sincos(angle[1], cp, sp);
         sincos(angle[2], cr, sr);
         cysp = rnd(cy * sp, 16);
         sysp = rnd(sy * sp, 16);
         rot[0] = sat(rnd(cy * cp, 16), 18);
         rot[1] = sat(rnd(cysp * sr, 16) - rnd(sy * cr, 16), 18);
         rot[2] = sat(rnd(cysp * cr, 16) + rnd(sy * sr, 16), 18);
         rot[3] = sat(rnd(sy * cp, 16), 18);
         rot[4] = sat(rnd(sysp * sr, 16) + rnd(cy * cr, 16), 18);
         rot[5] = sat(rnd(sysp * cr, 16) - rnd(cy * sr, 16), 18);
         rot[6] = sat(-sp, 18);
         rot[7] = sat(rnd(cp * sr, 16), 18);
         rot[8] = sat(rnd(cp * cr, 16), 18);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_YAW, CSR_PITCH, CSR_ROLL: begin
               angle[idx[1:0]] = data[15:0];
               rebuild_rotation();
            end
            CSR_OFFX, CSR_OFFY, CSR_OFFZ:
               offset[2'(idx - CSR_OFFX)] = longint'($signed(data));
            default: ;
         endcase
      endfunction

      function void note_detection(det_type d);
         track_type t;
         longint rng, rr, ca, sa, ce, se, acc, p;
         longint sv[3];
         rng = longint'(d.range);
         if (rng < RANGE_MIN || rng > RANGE_MAX) return;
         rr = longint'($signed(d.rr));
         sincos(d.az, ca, sa);
         sincos(d.el, ce, se);
         sv[0] = rnd(rng * ce * ca, 32);
         sv[1] = rnd(rng * ce * sa, 32);
         sv[2] = rnd(rng * se, 16);
         t.id = id_cnt;
         id_cnt = id_cnt + 1;
         for (int i = 0; i < 3; i++) begin
            acc = rot[3*i] * sv[0] + rot[3*i+1] * sv[1] + rot[3*i+2] * sv[2];
            p = sat(rnd(acc, 16) + offset[i], 18);
            t.pos[i] = p[17:0];
         end
         p = sat(-rnd(rr * ca, 16), 16);
         t.vx = p[15:0];
         p = sat(-rnd(rr * sa, 16), 16);
         t.vy = p[15:0];
         t.stamp = d.stamp;
         expected_q = {expected_q, t};
      endfunction

      function string check_result(track_type got);
         track_type e;
         string     msg;
         if (expected_q.size() == 0)
            return $sformatf("result id %0d with nothing expected", got.id);
         e = expected_q.pop_front();
         msg = "";
         if (got.id !== e.id)
            msg = {msg, $sformatf(" id %0d/%0d", got.id, e.id)};
         for (int i = 0; i < 3; i++)
            if (got.pos[i] !== e.pos[i])
               msg = {msg, $sformatf(" pos%0d %0d/%0d", i, $signed(got.pos[i]),
                                     $signed(e.pos[i]))};
         if (got.vx !== e.vx)
            msg = {msg, $sformatf(" vel_x %0d/%0d", $signed(got.vx), $signed(e.vx))};
         if (got.vy !== e.vy)
            msg = {msg, $sformatf(" vel_y %0d/%0d", $signed(got.vy), $signed(e.vy))};
         if (got.stamp !== e.stamp)
            msg = {msg, $sformatf(" stamp %h/%h", got.stamp, e.stamp)};
         if (msg != "") msg = {$sformatf("id %0d got/exp:", e.id), msg};
         return msg;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [15:0]                req_range = '0;
   logic signed [ANG_W-1:0]    req_azimuth = '0;
   logic signed [ANG_W-1:0]    req_elevation = '0;
   logic signed [15:0]         req_range_rate = '0;
   logic [STAMP_W-1:0]         req_timestamp = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [OBJ_ID_W-1:0]        rsp_object_id;
   logic signed [POS_W-1:0]    rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [VEL_W-1:0]    rsp_vel_x, rsp_vel_y;
   logic [STAMP_W-1:0]         rsp_stamp_out;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_W-1:0]           csr_wdata = '0;

   ego_scoreboard sb = new();
   int  errors = 0;
   bit  quiet = 1'b0;        // no idling on either side
   int  hold_requests = 0;   // long receiver hold-offs asked for

   radar_polar_to_ego_transform DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("radar_polar_to_ego_transform_tb: done, errors");
      $finish;
   end

   task automatic report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
   endtask

   // Receiver: check accepted results, stall in random bursts.
   initial begin
      track_type got;
      string     msg;
      int        stall_left, holds_done;
      stall_left = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.id = rsp_object_id;
            got.pos[0] = rsp_pos_x;
            got.pos[1] = rsp_pos_y;
            got.pos[2] = rsp_pos_z;
            got.vx = rsp_vel_x;
            got.vy = rsp_vel_y;
            got.stamp = rsp_stamp_out;
            msg = sb.check_result(got);
            if (msg != "") report(msg);
         end
         if (holds_done < hold_requests) begin
            holds_done++;
            stall_left = 400;
         end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 19);
         if (quiet && holds_done >= hold_requests) stall_left = 0;
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else
            rsp_ready <= 1'b1;
      end
   end

   task automatic send_det(det_type d);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_range      <= d.range;
      req_azimuth    <= d.az;
      req_elevation  <= d.el;
      req_range_rate <= d.rr;
      req_timestamp  <= d.stamp;
      do @(posedge clock); while (!req_ready);
      sb.note_detection(d);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Drop the request valid, then wait until every expected result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic det_type random_det();
      det_type d;
      d.range = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(RANGE_MIN, RANGE_MAX))
                                             : 16'($urandom);
      d.az    = 16'($urandom);
      d.el    = 16'($urandom);
      d.rr    = 16'($urandom);
      d.stamp = {$urandom, $urandom};
      return d;
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) send_det(random_det());
   endtask

   task automatic random_mounting();
      write_csr(CSR_YAW,   CSR_W'($urandom));
      write_csr(CSR_PITCH, CSR_W'($urandom));
      write_csr(CSR_ROLL,  CSR_W'($urandom));
      write_csr(CSR_OFFX,  CSR_W'($urandom));
      write_csr(CSR_OFFY,  CSR_W'($urandom));
      write_csr(CSR_OFFZ,  CSR_W'($urandom));
   endtask

   initial begin
      det_type d;
      logic [15:0] ranges[6];
      logic [15:0] angs[6];
      ranges = '{16'd0, 16'd127, 16'd128, 16'd51200, 16'd51201, 16'hFFFF};
      angs   = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000, 16'h3FFF};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Range filter edges, angle extremes and quarter boundaries, rate extremes.
      for (int i = 0; i < 6; i++) begin
         d.range = ranges[i];
         d.az = angs[i];
         d.el = angs[5 - i];
         d.rr = (i % 2) ? 16'h8000 : 16'h7FFF;
         d.stamp = (i % 2) ? '1 : '0;
         send_det(d);
      end
      for (int i = 0; i < 12; i++) begin
         d.range = (i < 6) ? 16'd51200 : 16'd128;
         d.az = angs[i % 6];
         d.el = angs[(i + 2) % 6];
         d.rr = (i % 3 == 0) ? 16'h8000 : 16'($urandom);
         d.stamp = {$urandom, $urandom};
         send_det(d);
      end
      drain();

      // Extreme mounting: saturating offsets, extreme angles, spare indexes ignored.
      write_csr(CSR_YAW,   17'h18000);
      write_csr(CSR_PITCH, 17'h07FFF);
      write_csr(CSR_ROLL,  17'h04000);
      write_csr(CSR_OFFX,  17'h0FFFF);
      write_csr(CSR_OFFY,  17'h10000);
      write_csr(CSR_OFFZ,  17'h00000);
      write_csr(CSR_SPARE_LO, CSR_W'($urandom));
      write_csr(CSR_SPARE_HI, CSR_W'($urandom));
      hold_requests++;
      random_phase(220);
      drain();

      random_mounting();
      random_phase(220);
      drain();

      random_mounting();
      hold_requests++;
      random_phase(220);
      drain();

      // Last part: no idling.
      random_mounting();
      quiet = 1'b1;
      random_phase(220);
      drain();

      if (errors == 0)
         $display("radar_polar_to_ego_transform_tb: done, clean");
      else
         $display("radar_polar_to_ego_transform_tb: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
hdl/rpte_pkg.sv
hdl/rpte_cordic.sv
hdl/rpte_mac.sv
hdl/radar_polar_to_ego_transform.sv
verif/radar_polar_to_ego_transform_tb.sv
